### hdl/lfds_pkg.sv
// Shared constants, command/status types and letter helpers for the frequency scorer.
`timescale 1ns / 1ps

package lfds_pkg;

    localparam int MAX_LENGTH    = 65536;
    localparam int LEN_W         = $clog2(MAX_LENGTH + 1);
    localparam int NUM_LETTERS   = 26;
    localparam int LETTER_W      = $clog2(NUM_LETTERS);
    localparam int FRAC_W        = 16;
    localparam int Q_W           = FRAC_W + 1;
    localparam int STEP_W        = $clog2(FRAC_W);
    localparam int PEN_W         = 16;
    localparam int SCORE_W       = 32;
    localparam int ACC_W         = SCORE_W + 1;
    localparam logic [PEN_W-1:0] PENALTY_RESET = 16'd6554;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;

    typedef struct packed {
        logic                absorb;
        logic                div_init;
        logic                div_step;
        logic                acc_load;
        logic                acc_add;
        logic                finish;
        logic [LETTER_W-1:0] letter_idx;
    } cmd_t;

    typedef struct packed {
        logic count_zero;
    } status_t;

    function automatic logic is_letter(input logic [7:0] b);
        return ((b >= CHAR_UPPER_A) && (b <= CHAR_UPPER_Z)) ||
               ((b >= CHAR_LOWER_A) && (b <= CHAR_LOWER_Z));
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    endfunction

    // Both cases sit at 0x01..0x1A in the low five bits.
    function automatic logic [LETTER_W-1:0] letter_index(input logic [7:0] b);
        return LETTER_W'(b[4:0] - 5'd1);
    endfunction

    // Expected English letter frequency, Q0.16.
    function automatic logic [FRAC_W-1:0] exp_freq(input logic [LETTER_W-1:0] idx);
        logic [FRAC_W-1:0] e;
        case (idx)
            5'd0:    e = 16'd5322;
            5'd1:    e = 16'd976;
            5'd2:    e = 16'd1776;
            5'd3:    e = 16'd2831;
            5'd4:    e = 16'd7877;
            5'd5:    e = 16'd1507;
            5'd6:    e = 16'd1330;
            5'd7:    e = 16'd3880;
            5'd8:    e = 16'd4791;
            5'd9:    e = 16'd66;
            5'd10:   e = 16'd452;
            5'd11:   e = 16'd2608;
            5'd12:   e = 16'd1710;
            5'd13:   e = 16'd4555;
            5'd14:   e = 16'd5033;
            5'd15:   e = 16'd1193;
            5'd16:   e = 16'd72;
            5'd17:   e = 16'd3945;
            5'd18:   e = 16'd4116;
            5'd19:   e = 16'd5964;
            5'd20:   e = 16'd1887;
            5'd21:   e = 16'd727;
            5'd22:   e = 16'd1370;
            5'd23:   e = 16'd111;
            5'd24:   e = 16'd1383;
            5'd25:   e = 16'd46;
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage

### hdl/lfds_ctrl.sv
// Controller: byte intake, per-letter divide/accumulate sequencing and result handoff.
`timescale 1ns / 1ps

module lfds_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_last_byte,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    input  lfds_pkg::status_t status,
    output lfds_pkg::cmd_t    cmd
);
    import lfds_pkg::*;

    typedef enum logic [4:0] {
        S_ACCEPT   = 5'b00001,
        S_INIT     = 5'b00010,
        S_DIV      = 5'b00100,
        S_ACC      = 5'b01000,
        S_WAIT_OUT = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [LETTER_W-1:0] idx_reg, idx_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                out_valid_reg, out_valid_next;

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.letter_idx = idx_reg;
        s_ready    = 1'b0;
        case (state_reg)
            S_ACCEPT: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.absorb = 1'b1;
                    if (s_last_byte) begin
                        idx_next   = '0;
                        state_next = S_INIT;
                    end
                end
            end
            S_INIT: begin
                cmd.div_init = 1'b1;
                cmd.acc_load = (idx_reg == '0);
                step_next    = '0;
                // an empty bin has quotient zero: skip the divide
                state_next   = status.count_zero ? S_ACC : S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(FRAC_W - 1)) begin
                    state_next = S_ACC;
                end
            end
            S_ACC: begin
                cmd.acc_add = 1'b1;
                if (idx_reg == LETTER_W'(NUM_LETTERS - 1)) begin
                    state_next = S_WAIT_OUT;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_INIT;
                end
            end
            S_WAIT_OUT: begin
                // hold until the output slot is free
                if (!out_valid_reg || m_ready) begin
                    cmd.finish = 1'b1;
                    state_next = S_ACCEPT;
                end
            end
            default: begin
                state_next = S_ACCEPT;
            end
        endcase
    end

    always_comb begin
        if (cmd.finish) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_valid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_ACCEPT;
            idx_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### hdl/lfds_dp.sv
// Datapath: histogram, length and penalty counters, radix-2 divider, score accumulator.
`timescale 1ns / 1ps

module lfds_dp (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [lfds_pkg::PEN_W-1:0]   cfg_wr_data,
    input  logic [7:0]                   s_text_byte,
    input  lfds_pkg::cmd_t               cmd,
    output lfds_pkg::status_t            status,
    output logic [lfds_pkg::SCORE_W-1:0] m_score,
    output logic                         m_score_saturated
);
    import lfds_pkg::*;

    logic [LEN_W-1:0]   counts_reg [NUM_LETTERS];
    logic [LEN_W-1:0]   counts_next [NUM_LETTERS];
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [SCORE_W-1:0] pen_sum_reg, pen_sum_next;
    logic               sat_reg, sat_next;
    logic [PEN_W-1:0]   penalty_reg;
    logic [LEN_W-1:0]   rem_reg, rem_next;
    logic [Q_W-1:0]     quo_reg, quo_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [SCORE_W-1:0] score_reg;
    logic               score_sat_reg;

    logic [LEN_W-1:0]   sel_count;
    logic [SCORE_W:0]   pen_add;
    logic [LEN_W:0]     rem_dbl;
    logic [Q_W-1:0]     exp_q;
    logic [Q_W-1:0]     diff;

    assign sel_count         = counts_reg[cmd.letter_idx];
    assign status.count_zero = (sel_count == '0);
    assign pen_add           = {1'b0, pen_sum_reg} + (SCORE_W + 1)'(penalty_reg);
    assign rem_dbl           = {rem_reg, 1'b0};
    assign exp_q             = {1'b0, exp_freq(cmd.letter_idx)};
    assign diff              = (quo_reg >= exp_q) ? (quo_reg - exp_q) : (exp_q - quo_reg);

    // histogram, length and penalty
    always_comb begin
        counts_next  = counts_reg;
        len_next     = len_reg;
        pen_sum_next = pen_sum_reg;
        sat_next     = sat_reg;
        if (cmd.absorb) begin
            if (len_reg == LEN_W'(MAX_LENGTH)) begin
                // drop bytes past the length limit
                sat_next = 1'b1;
            end else begin
                len_next = len_reg + 1'b1;
                if (is_letter(s_text_byte)) begin
                    counts_next[letter_index(s_text_byte)] =
                        counts_reg[letter_index(s_text_byte)] + 1'b1;
                end else if (!is_digit(s_text_byte)) begin
                    if (pen_add[SCORE_W]) begin
                        pen_sum_next = '1;
                        sat_next     = 1'b1;
                    end else begin
                        pen_sum_next = pen_add[SCORE_W-1:0];
                    end
                end
            end
        end
        if (cmd.finish) begin
            for (int i = 0; i < NUM_LETTERS; i++) begin
                counts_next[i] = '0;
            end
            len_next     = '0;
            pen_sum_next = '0;
            sat_next     = 1'b0;
        end
    end

    // restoring division of count * 2^FRAC_W by the length, one bit per step
    always_comb begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (cmd.div_init) begin
            if (sel_count == len_reg) begin
                rem_next = '0;
                quo_next = Q_W'(1);
            end else begin
                rem_next = sel_count;
                quo_next = '0;
            end
        end else if (cmd.div_step) begin
            if (rem_dbl >= {1'b0, len_reg}) begin
                rem_next = LEN_W'(rem_dbl - {1'b0, len_reg});
                quo_next = {quo_reg[Q_W-2:0], 1'b1};
            end else begin
                rem_next = rem_dbl[LEN_W-1:0];
                quo_next = {quo_reg[Q_W-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        acc_next = acc_reg;
        if (cmd.acc_load) begin
            acc_next = {1'b0, pen_sum_reg};
        end else if (cmd.acc_add) begin
            acc_next = acc_reg + ACC_W'(diff);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_LETTERS; i++) begin
                counts_reg[i] <= '0;
            end
            len_reg     <= '0;
            pen_sum_reg <= '0;
            sat_reg     <= 1'b0;
            penalty_reg <= PENALTY_RESET;
        end else begin
            counts_reg  <= counts_next;
            len_reg     <= len_next;
            pen_sum_reg <= pen_sum_next;
            sat_reg     <= sat_next;
            if (cfg_wr_en) begin
                penalty_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        acc_reg <= acc_next;
        if (cmd.finish) begin
            score_reg     <= acc_reg[SCORE_W] ? '1 : acc_reg[SCORE_W-1:0];
            score_sat_reg <= sat_reg | acc_reg[SCORE_W];
        end
    end

    assign m_score           = score_reg;
    assign m_score_saturated = score_sat_reg;

endmodule

### hdl/letter_frequency_distance_scorer.sv
// Top level of the letter frequency distance scorer: controller, datapath and checks.
// Throughput: a byte that is not last is taken every cycle.
// Scoring: after the last byte, each letter passes through an init and an accumulate state,
//   with the divider steps between them when that letter occurred, then the result waits
//   for a free output slot; no byte is taken while a string is scored.
// Reset (aresetn low, synchronous): histogram, length, penalty sum and output valid cleared;
//   the penalty register returns to 6554 (0.1 in Q0.16).
`timescale 1ns / 1ps

module letter_frequency_distance_scorer (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [lfds_pkg::PEN_W-1:0]   cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [7:0]                   s_text_byte,
    input  logic                         s_last_byte,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [lfds_pkg::SCORE_W-1:0] m_score,
    output logic                         m_score_saturated
);
    import lfds_pkg::*;

    cmd_t    cmd;
    status_t status;

    lfds_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_last_byte (s_last_byte),
        .s_ready     (s_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .status      (status),
        .cmd         (cmd)
    );

    lfds_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_text_byte       (s_text_byte),
        .cmd               (cmd),
        .status            (status),
        .m_score           (m_score),
        .m_score_saturated (m_score_saturated)
    );

`ifndef ASSERT_OFF
    // never overwrite a result that has not been taken
    a_finish_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> (!m_valid || m_ready))
        else $error("result loaded while output slot busy");

    // a last item closes intake until its score is out
    a_last_closes_intake: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_last_byte) |=> !s_ready)
        else $error("intake open after last item");

    // divider steps and byte intake never overlap
    a_no_absorb_in_divide: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.div_step || cmd.acc_add) |-> !s_ready)
        else $error("intake open during scoring");

    // a finished result shows on the output next cycle
    a_finish_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> m_valid)
        else $error("result not presented after load");
`endif

endmodule

### tb/sv/letter_frequency_distance_scorer_test.sv
// Self-checking testbench for the letter frequency distance scorer.
`timescale 1ns / 1ps

module letter_frequency_distance_scorer_test;

    import lfds_pkg::*;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic               sat;
    } score_t;

    typedef enum int {ROW_BYTE, ROW_CFG} row_kind_t;
    typedef enum int {SINK_OPEN, SINK_COIN, SINK_QUARTER, SINK_SPARSE} sink_mode_t;

    typedef struct {
        row_kind_t    kind;
        logic [7:0]   text;
        logic         last;
        int           reps;
        bit           typed;
        score_t       typed_res;
    } row_t;

    localparam int SCORE_LATENCY_MAX = 53 + 16 * NUM_LETTERS;
    localparam longint unsigned SCORE_CAP = 64'hFFFF_FFFF;

    // English letter frequencies, Q0.16, a through z.
    localparam int unsigned ENGLISH_Q16 [NUM_LETTERS] = '{
        5322, 976, 1776, 2831, 7877, 1507, 1330, 3880, 4791, 66,
        452, 2608, 1710, 4555, 5033, 1193, 72, 3945, 4116, 5964,
        1887, 727, 1370, 111, 1383, 46
    };

    localparam int SCRIPT_ROWS = 29;
    row_t script [SCRIPT_ROWS] = '{
        '{ROW_BYTE, 8'h21, 1'b1, 1,     1'b1, '{32'd72082, 1'b0}},
        '{ROW_BYTE, 8'h39, 1'b1, 1,     1'b1, '{32'd65528, 1'b0}},
        '{ROW_BYTE, 8'h30, 1'b1, 1,     1'b1, '{32'd65528, 1'b0}},
        '{ROW_BYTE, 8'h41, 1'b0, 1,     1'b0, '{32'd0, 1'b0}},
        '{ROW_BYTE, 8'h61, 1'b0, 1,     1'b0, '{32'd0, 1'b0}},
        '{ROW_BYTE, 8'h5A, 1'b0, 1,     1'b0, '{32'd0, 1'b0}},
        '{ROW_BYTE, 8'h7A, 1'b0, 1,     1'b0, '{32'd0, 1'b0}},
        '{ROW_BYTE, 8'h40, 1'b0, 1,     1'b0, '{32'd0, 1'b0}},
        '{ROW_BYTE, 8'h5B, 1'b0, 1,     1'b0, '{32'd0, 1'b0}},
        '{ROW_BYTE, 8'h60, 1'b0, 1,     1'b0, '{32'd0, 1'b0}},
        '{ROW_BYTE, 8'h7B, 1'b0, 1,     1'b0, '{32'd0, 1'b0}},
        '{ROW_BYTE, 8'h2F, 1'b0, 1,     1'b0, '{32'd0, 1'b0}},
        '{ROW_BYTE, 8'h3A, 1'b0, 1,     1'b0, '{32'd0, 1'b0}},
        '{ROW_BYTE, 8'h00, 1'b0, 1,     1'b0, '{32'd0, 1'b0}},
        '{ROW_BYTE, 8'h7F, 1'b0, 1,     1'b0, '{32'd0, 1'b0}},
        '{ROW_BYTE, 8'h80, 1'b0, 1,     1'b0, '{32'd0, 1'b0}},
        '{ROW_BYTE, 8'h45, 1'b1, 1,     1'b0, '{32'd0, 1'b0}},
        '{ROW_BYTE, 8'hFF, 1'b1, 1,     1'b1, '{32'd72082, 1'b0}},
        '{ROW_CFG,  8'h00, 1'b0, 0,     1'b0, '{32'd0, 1'b0}},
        '{ROW_BYTE, 8'hFF, 1'b1, 1,     1'b1, '{32'd65528, 1'b0}},
        '{ROW_CFG,  8'hFF, 1'b0, 65535, 1'b0, '{32'd0, 1'b0}},
        '{ROW_BYTE, 8'hFF, 1'b1, 1,     1'b1, '{32'd131063, 1'b0}},
        // exactly MAX_LENGTH bytes of one letter: its quotient is 1.0
        '{ROW_BYTE, 8'h65, 1'b0, 65535, 1'b0, '{32'd0, 1'b0}},
        '{ROW_BYTE, 8'h65, 1'b1, 1,     1'b0, '{32'd0, 1'b0}},
        // overlong: the trailing letter is dropped and the length saturates
        '{ROW_BYTE, 8'hFF, 1'b0, 65536, 1'b0, '{32'd0, 1'b0}},
        '{ROW_BYTE, 8'h71, 1'b1, 1,     1'b1, '{32'hFFFF_FFF8, 1'b1}},
        '{ROW_CFG,  8'h00, 1'b0, 1,     1'b0, '{32'd0, 1'b0}},
        '{ROW_BYTE, 8'h23, 1'b1, 1,     1'b1, '{32'd65529, 1'b0}},
        '{ROW_BYTE, 8'h78, 1'b1, 1,     1'b0, '{32'd0, 1'b0}}
    };

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [PEN_W-1:0]    cfg_wr_data = '0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [7:0]          s_text_byte = '0;
    logic                s_last_byte = 1'b0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [SCORE_W-1:0]  m_score;
    logic                m_score_saturated;

    // Shadow of the block's string state
    logic [LEN_W-1:0]    letter_hist [NUM_LETTERS];
    logic [LEN_W-1:0]    text_len;
    logic [SCORE_W-1:0]  penalty_acc;
    logic                sticky_sat;
    logic [PEN_W-1:0]    penalty_cfg = PENALTY_RESET;

    score_t              pending_scores [$];
    int                  mismatch_count = 0;
    int                  scores_seen = 0;
    int                  burst_left = 0;

    letter_frequency_distance_scorer dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_text_byte       (s_text_byte),
        .s_last_byte       (s_last_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_score           (m_score),
        .m_score_saturated (m_score_saturated)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(64'd20_000_000);
        $display("** letter_frequency_distance_scorer: FAILED **");
        $finish;
    end

    task automatic clear_text_state();
        for (int i = 0; i < NUM_LETTERS; i++) letter_hist[i] = '0;
        text_len    = '0;
        penalty_acc = '0;
        sticky_sat  = 1'b0;
    endtask

    // Fold one byte into the histogram, length and penalty sum; on the last byte form the score.
    task automatic absorb_text_byte(input logic [7:0] b, input logic last,
                                    output logic done, output score_t res);
        longint unsigned total;
        longint unsigned q;
        longint unsigned e;
        longint unsigned len;
        done = 1'b0;
        res  = '0;
        if (text_len >= MAX_LENGTH) begin
            sticky_sat = 1'b1;
        end else begin
            text_len = text_len + 1'b1;
            if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
                letter_hist[b - CHAR_UPPER_A] = letter_hist[b - CHAR_UPPER_A] + 1'b1;
            end else if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z) begin
                letter_hist[b - CHAR_LOWER_A] = letter_hist[b - CHAR_LOWER_A] + 1'b1;
            end else if (!(b >= CHAR_ZERO && b <= CHAR_NINE)) begin
                total = longint'(penalty_acc) + longint'(penalty_cfg);
                if (total > SCORE_CAP) begin
                    total      = SCORE_CAP;
                    sticky_sat = 1'b1;
                end
                penalty_acc = total[SCORE_W-1:0];
            end
        end
        if (last) begin
            len   = (text_len == 0) ? 64'd1 : longint'(text_len);
            total = longint'(penalty_acc);
            for (int i = 0; i < NUM_LETTERS; i++) begin
                q = (longint'(letter_hist[i]) << FRAC_W) / len;
                e = longint'(ENGLISH_Q16[i]);
                total += (q >= e) ? (q - e) : (e - q);
            end
            if (total > SCORE_CAP) begin
                total      = SCORE_CAP;
                sticky_sat = 1'b1;
            end
            res.score = total[SCORE_W-1:0];
            res.sat   = sticky_sat;
            done      = 1'b1;
            clear_text_state();
        end
    endtask

    // Offer one item in bursts with random gaps, then predict on acceptance.
    task automatic send_text_byte(input logic [7:0] b, input logic last,
                                  input bit typed, input score_t typed_res);
        logic   done;
        score_t predicted;
        int     gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 2) == 0) begin
                gap        = 0;
                burst_left = $urandom_range(20, 200);
            end else begin
                gap        = $urandom_range(1, 6);
                burst_left = $urandom_range(1, 24);
            end
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_text_byte <= b;
        s_last_byte <= last;
        do @(posedge aclk); while (!s_ready);
        absorb_text_byte(b, last, done, predicted);
        if (done) pending_scores.push_back(typed ? typed_res : predicted);
    endtask

    // Drop valid, let every score come out and the block go quiet.
    task automatic settle_block();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_scores.size() != 0) @(posedge aclk);
        repeat (2 * SCORE_LATENCY_MAX) @(posedge aclk);
    endtask

    task automatic write_penalty(input logic [PEN_W-1:0] value);
        settle_block();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        penalty_cfg = value;
    endtask

    // Receiver: changing ready patterns, plus one long hold-off to back up the input.
    initial begin : score_sink
        sink_mode_t mode;
        int         mode_left;
        int         hold_left;
        int         phase_cnt;
        bit         hold_done;
        mode      = SINK_OPEN;
        mode_left = 0;
        hold_left = 0;
        phase_cnt = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            phase_cnt++;
            if (!hold_done && scores_seen >= 15) begin
                hold_left = 4000;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = sink_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 300);
                end
                mode_left--;
                case (mode)
                    SINK_OPEN:    m_ready <= 1'b1;
                    SINK_COIN:    m_ready <= 1'($urandom_range(0, 1));
                    SINK_QUARTER: m_ready <= (phase_cnt % 4 == 0);
                    default:      m_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    initial begin : score_check
        score_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                scores_seen++;
                if (pending_scores.size() == 0) begin
                    $display("%0t: unexpected score %h sat %b", $time, m_score,
                             m_score_saturated);
                    mismatch_count++;
                end else begin
                    want = pending_scores.pop_front();
                    if (m_score !== want.score) begin
                        $display("%0t: score expected %h actual %h", $time, want.score,
                                 m_score);
                        mismatch_count++;
                    end
                    if (m_score_saturated !== want.sat) begin
                        $display("%0t: score_saturated expected %b actual %b", $time,
                                 want.sat, m_score_saturated);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    initial begin : stimulus
        int         left;
        int         slen;
        int         pick;
        logic [7:0] b;
        clear_text_state();
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < SCRIPT_ROWS; r++) begin
            if (script[r].kind == ROW_CFG) begin
                write_penalty(PEN_W'(script[r].reps));
            end else begin
                for (int k = 0; k < script[r].reps; k++) begin
                    send_text_byte(script[r].text, script[r].last && (k == script[r].reps - 1),
                                   script[r].typed, script[r].typed_res);
                end
            end
        end

        for (int phase = 0; phase < 5; phase++) begin
            write_penalty((phase == 0) ? PENALTY_RESET : PEN_W'($urandom_range(0, 65535)));
            left = 100;
            while (left > 0) begin
                pick = $urandom_range(0, 19);
                if (pick < 16) slen = $urandom_range(1, 12);
                else if (pick < 19) slen = $urandom_range(13, 40);
                else slen = $urandom_range(41, 120);
                for (int k = 0; k < slen; k++) begin
                    pick = $urandom_range(0, 9);
                    case (pick)
                        0, 1, 2, 3: b = CHAR_LOWER_A + 8'($urandom_range(0, 25));
                        4:          b = CHAR_UPPER_A + 8'($urandom_range(0, 25));
                        5:          b = 8'h20;
                        6:          b = CHAR_ZERO + 8'($urandom_range(0, 9));
                        7:          b = 8'($urandom_range(8'h21, 8'h2F));
                        default:    b = 8'($urandom_range(0, 255));
                    endcase
                    send_text_byte(b, k == slen - 1, 1'b0, '0);
                end
                left -= slen;
            end
        end

        settle_block();
        if (mismatch_count == 0) begin
            $display("** letter_frequency_distance_scorer: PASSED **");
        end else begin
            $display("** letter_frequency_distance_scorer: FAILED **");
        end
        $finish;
    end

endmodule

### letter_frequency_distance_scorer.f
hdl/lfds_pkg.sv
hdl/lfds_ctrl.sv
hdl/lfds_dp.sv
hdl/letter_frequency_distance_scorer.sv
tb/sv/letter_frequency_distance_scorer_test.sv
